>>> rtl/core/csfp_pkg.sv
// Types, codes and name tables shared by the timestamp parser.
`default_nettype none

package csfp_pkg;

  localparam logic [7:0] BLANK_CODE = 8'd32;
  localparam logic [7:0] COLON_CODE = 8'd58;

  // Token positions within the timestamp
  localparam logic [2:0] TOK_WEEKDAY = 3'd0;
  localparam logic [2:0] TOK_MONTH   = 3'd1;
  localparam logic [2:0] TOK_DAY     = 3'd2;
  localparam logic [2:0] TOK_TIME    = 3'd3;
  localparam logic [2:0] TOK_YEAR    = 3'd4;
  localparam logic [2:0] TOK_CAP     = 3'd5;

  localparam logic [2:0] CHARS_CAP = 3'd7;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_item_t;

  typedef struct packed {
    logic [13:0] year_value;
    logic [3:0]  month_number;
    logic [6:0]  day_of_month;
    logic [2:0]  weekday_number;
    logic [6:0]  hour_value;
    logic [6:0]  minute_value;
    logic [6:0]  second_value;
  } result_item_t;

  typedef struct packed {
    logic [2:0]  token_index;
    logic [2:0]  chars_in_token;
    logic [15:0] letter_buffer;
    logic [2:0]  weekday_held;
    logic [3:0]  month_held;
    logic [6:0]  day_accum;
    logic [6:0]  hour_accum;
    logic [6:0]  minute_accum;
    logic [6:0]  second_accum;
    logic [13:0] year_accum;
    logic        in_token;
    logic        stopped;
    logic [1:0]  colons;
  } parse_state_t;

  // Key holds the three characters first-to-last, MSB first
  function automatic logic [2:0] weekday_lookup(input logic [23:0] key);
    logic [2:0] num;
    case (key)
      "Mon":   num = 3'd1;
      "Tue":   num = 3'd2;
      "Wed":   num = 3'd3;
      "Thu":   num = 3'd4;
      "Fri":   num = 3'd5;
      "Sat":   num = 3'd6;
      "Sun":   num = 3'd7;
      default: num = 3'd0;
    endcase
    return num;
  endfunction

  function automatic logic [3:0] month_lookup(input logic [23:0] key);
    logic [3:0] num;
    case (key)
      "Jan":   num = 4'd1;
      "Feb":   num = 4'd2;
      "Mar":   num = 4'd3;
      "Apr":   num = 4'd4;
      "May":   num = 4'd5;
      "Jun":   num = 4'd6;
      "Jul":   num = 4'd7;
      "Aug":   num = 4'd8;
      "Sep":   num = 4'd9;
      "Oct":   num = 4'd10;
      "Nov":   num = 4'd11;
      "Dec":   num = 4'd12;
      default: num = 4'd0;
    endcase
    return num;
  endfunction

  // End of a value part; by_colon is set when a ':' ended it
  function automatic parse_state_t close_part(input parse_state_t s, input logic by_colon);
    parse_state_t r;
    logic         len_ok;
    r      = s;
    len_ok = (s.chars_in_token == 3'd1) || (s.chars_in_token == 3'd2);
    if (s.token_index == TOK_DAY) begin
      if (!len_ok) r.day_accum = '0;
    end else if (s.token_index == TOK_TIME) begin
      case (s.colons)
        2'd0: begin
          if (!(by_colon && len_ok)) r.hour_accum = '0;
        end
        2'd1: begin
          if (!(by_colon && len_ok)) r.minute_accum = '0;
        end
        default: begin
          if (!len_ok) r.second_accum = '0;
        end
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ctime_string_field_parser_core.sv
// Streaming parser for "Www Mmm dd hh:mm:ss yyyy" timestamps, one character per item.
//
// Characters arrive on the char channel (valid/ready), one per item; the item
// with last_char set closes the string. One result item per string then leaves
// on the result channel: weekday, month, day, hour, minute, second and year.
// Runs of blanks separate tokens; leading blanks are skipped.
//
// Throughput is one character per cycle unless a final character waits on a
// pending result: each character passes through an input register and a short
// update of the token state, set by that single state register. result_valid
// is registered and set as the last character leaves the input register.
//
// A finished result sits in the result register; while it waits, non-final
// characters keep flowing. A second final character waits in the input register
// until the result is taken, and char_ready stays low for that time.
//
// Synchronous reset clears the parse state and both valid flags; the parse
// state also returns to reset after every final character.
`default_nettype none

module ctime_string_field_parser_core
  import csfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         char_valid,
  output logic              char_ready,
  input  wire char_item_t   char_item,
  output logic              result_valid,
  input  wire logic         result_ready,
  output result_item_t      result_item
);

  logic         held_valid;
  char_item_t   held_item;
  logic         advance;
  parse_state_t parse_state;
  parse_state_t work;
  parse_state_t fin;
  logic [7:0]   c;
  logic [2:0]   p;
  logic         is_digit;

  assign advance    = held_valid && (!held_item.last_char || !result_valid || result_ready);
  assign char_ready = !held_valid || advance;
  assign c          = held_item.char_code;
  assign is_digit   = (c >= "0") && (c <= "9");

  always_comb begin
    work = parse_state;
    p    = parse_state.chars_in_token;
    if (c == BLANK_CODE) begin
      if (parse_state.in_token) begin
        work                = close_part(parse_state, 1'b0);
        work.in_token       = 1'b0;
        work.stopped        = 1'b0;
        work.colons         = 2'd0;
        work.chars_in_token = '0;
        if (parse_state.token_index < TOK_CAP)
          work.token_index = parse_state.token_index + 3'd1;
      end
    end else begin
      if (!parse_state.in_token) begin
        work.in_token       = 1'b1;
        work.stopped        = 1'b0;
        work.colons         = 2'd0;
        work.chars_in_token = '0;
        p                   = '0;
      end
      if (work.token_index == TOK_TIME && c == COLON_CODE && work.colons < 2'd2) begin
        work                = close_part(work, 1'b1);
        work.colons         = work.colons + 2'd1;
        work.stopped        = 1'b0;
        work.chars_in_token = '0;
      end else begin
        case (work.token_index)
          TOK_WEEKDAY, TOK_MONTH: begin
            if (p == 3'd0) begin
              work.letter_buffer = {8'd0, c};
            end else if (p == 3'd1) begin
              work.letter_buffer[15:8] = c;
            end else if (p == 3'd2) begin
              if (work.token_index == TOK_WEEKDAY)
                work.weekday_held = weekday_lookup({work.letter_buffer[7:0],
                                                    work.letter_buffer[15:8], c});
              else
                work.month_held = month_lookup({work.letter_buffer[7:0],
                                                work.letter_buffer[15:8], c});
            end
          end
          TOK_DAY: begin
            if (p < 3'd2) begin
              if (!work.stopped && is_digit)
                work.day_accum = 7'(work.day_accum * 7'd10 + {3'd0, c[3:0]});
              else
                work.stopped = 1'b1;
            end
          end
          TOK_TIME: begin
            if (p < 3'd2) begin
              if (work.stopped || !is_digit) begin
                work.stopped = 1'b1;
              end else begin
                case (work.colons)
                  2'd0: work.hour_accum =
                          7'(work.hour_accum * 7'd10 + {3'd0, c[3:0]});
                  2'd1: work.minute_accum =
                          7'(work.minute_accum * 7'd10 + {3'd0, c[3:0]});
                  default: work.second_accum =
                          7'(work.second_accum * 7'd10 + {3'd0, c[3:0]});
                endcase
              end
            end
          end
          TOK_YEAR: begin
            if (p < 3'd4) begin
              if (!work.stopped && is_digit)
                work.year_accum = 14'(work.year_accum * 14'd10 + {10'd0, c[3:0]});
              else
                work.stopped = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (p < CHARS_CAP)
          work.chars_in_token = p + 3'd1;
      end
    end
  end

  // Closing the open part at the end of the string affects only the result
  assign fin = work.in_token ? close_part(work, 1'b0) : work;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (char_ready) begin
      held_valid <= char_valid;
    end
    if (char_ready && char_valid) held_item <= char_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= '0;
    end else if (advance) begin
      parse_state <= held_item.last_char ? '0 : work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && held_item.last_char) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (advance && held_item.last_char) begin
      result_item.year_value     <= fin.year_accum;
      result_item.month_number   <= fin.month_held;
      result_item.day_of_month   <= fin.day_accum;
      result_item.weekday_number <= fin.weekday_held;
      result_item.hour_value     <= fin.hour_accum;
      result_item.minute_value   <= fin.minute_accum;
      result_item.second_value   <= fin.second_accum;
    end
  end

endmodule

`default_nettype wire
